[rtl/knn_pkg.sv]
// Shared constants, codes and types of the k-nearest-neighbour selector.
package knn_pkg;

   localparam int COORD_W        = 16;
   localparam int ID_W           = 16;
   localparam int DIST_W         = 36;
   localparam int SQ_W           = 32;
   localparam int OP_W           = 2;
   localparam int K_W            = 4;
   localparam int DEF_LIST_DEPTH = 8;

   localparam int REQ_DATA_W = 3 * COORD_W;
   localparam int RSP_DATA_W = ((ID_W + DIST_W + 7) / 8) * 8;

   localparam logic [K_W-1:0]    K_RESET  = K_W'(8);
   localparam logic [DIST_W-1:0] DIST_INF = '1;

   localparam logic [OP_W-1:0] OP_COORD = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic [DIST_W-1:0] sq_dist;
      logic [ID_W-1:0]   id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic load;
      logic square;
      logic accum;
      logic last;
      logic clear;
   } sqacc_ctrl_type;

endpackage

[rtl/knn_topk_selector_unit.sv]
// A coordinate beat is accepted, squared in the shared multiplier, then added into the
// saturating 36-bit sum. On the final coordinate of a point the sorted list, held in a
// RAM with one read and one write port, is walked from the worst entry upward, each entry
// read, then compared and shifted. A read-out beat emits k results (one for k = 0, at most
// LIST_DEPTH), worst entry first, stalling while a result waits on rsp_tready; a clear
// empties the list. The RAM read port sets the pace of both walks. Input is taken only between
// items; the last result beat may still wait on rsp_tready while the next item is taken.
module knn_topk_selector_unit #(
   parameter int LIST_DEPTH = knn_pkg::DEF_LIST_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: point_coord[15:0], query_coord[31:16], point_id[47:32]
   input  logic [knn_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: op[1:0]
   input  logic [knn_pkg::OP_W-1:0]          req_tuser,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: entry_id[15:0], entry_dist[51:16], zero pad[55:52]
   output logic [knn_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tuser: entry_valid[0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wr_en,
   input  logic [knn_pkg::K_W-1:0]           csr_wr_data
);
   import knn_pkg::*;

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SQ      = 3'd1;
   localparam logic [2:0] S_ACC     = 3'd2;
   localparam logic [2:0] S_INS_RD  = 3'd3;
   localparam logic [2:0] S_INS_CMP = 3'd4;
   localparam logic [2:0] S_INS_WR  = 3'd5;
   localparam logic [2:0] S_RO_RD   = 3'd6;
   localparam logic [2:0] S_RO_LOAD = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [IDX_W-1:0]      rp_ff, rp_in;
   logic                  first_ff, first_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic                  last_ff, last_in;
   logic [LIST_DEPTH-1:0] valid_ff, valid_in;
   logic [K_W-1:0]        k_ff, k_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic                  rsp_tlast_ff, rsp_tlast_in;
   logic                  rsp_user_ff, rsp_user_in;
   entry_type             rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]      rd_addr_ff;

   logic                  req_fire;
   logic [IDX_W-1:0]      k_last;
   sqacc_ctrl_type        sq_ctrl;
   logic [DIST_W-1:0]     cand_dist;
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   entry_type             ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0]    ram_rd_data;
   entry_type             ent_raw;
   entry_type             ent;
   logic                  ent_valid;

   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      if (k_ff == '0) begin
         k_last = '0;
      end else if (int'(k_ff) > LIST_DEPTH) begin
         k_last = IDX_W'(LIST_DEPTH - 1);
      end else begin
         k_last = IDX_W'(k_ff - K_W'(1));
      end
   end

   knn_sqacc u_sqacc (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (sq_ctrl),
      .point_coord (req_tdata[COORD_W-1:0]),
      .query_coord (req_tdata[2*COORD_W-1:COORD_W]),
      .sum_dist    (cand_dist)
   );

   knn_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LIST_DEPTH),
      .AW    (IDX_W)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // empty entries read as the cleared value
   always_comb begin
      ent_raw     = entry_type'(ram_rd_data);
      ent_valid   = valid_ff[rd_addr_ff];
      ent.sq_dist = ent_valid ? ent_raw.sq_dist : DIST_INF;
      ent.id      = ent_valid ? ent_raw.id : '0;
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      rp_in         = rp_ff;
      first_in      = first_ff;
      id_in         = id_ff;
      last_in       = last_ff;
      valid_in      = valid_ff;
      k_in          = csr_wr_en ? csr_wr_data : k_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_data_in   = rsp_data_ff;
      sq_ctrl       = '0;
      sq_ctrl.last  = last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pos_ff;
      ram_wr_data   = '{sq_dist: cand_dist, id: id_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  OP_COORD: begin
                     sq_ctrl.load = 1'b1;
                     id_in        = req_tdata[3*COORD_W-1:2*COORD_W];
                     last_in      = req_tlast;
                     state_in     = S_SQ;
                  end
                  OP_CLEAR: begin
                     sq_ctrl.clear = 1'b1;
                     valid_in      = '0;
                  end
                  OP_READ: begin
                     rp_in    = '0;
                     state_in = S_RO_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_SQ: begin
            sq_ctrl.square = 1'b1;
            state_in       = S_ACC;
         end
         S_ACC: begin
            sq_ctrl.accum = 1'b1;
            pos_in        = '0;
            rp_in         = '0;
            first_in      = 1'b1;
            state_in      = last_ff ? S_INS_RD : S_IDLE;
         end
         S_INS_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_INS_CMP;
         end
         S_INS_CMP: begin
            if (first_ff) begin
               first_in = 1'b0;
               if (!(cand_dist < ent.sq_dist)) begin
                  state_in = S_IDLE;
               end else if (pos_ff == k_last) begin
                  state_in = S_INS_WR;
               end else begin
                  rp_in    = pos_ff + IDX_W'(1);
                  state_in = S_INS_RD;
               end
            end else if (ent.sq_dist >= cand_dist) begin
               // shift the entry that is no nearer than the candidate down one slot toward the worst end
               ram_wr_en        = 1'b1;
               ram_wr_data      = ent;
               valid_in[pos_ff] = ent_valid;
               pos_in           = rp_ff;
               if (rp_ff == k_last) begin
                  state_in = S_INS_WR;
               end else begin
                  rp_in    = rp_ff + IDX_W'(1);
                  state_in = S_INS_RD;
               end
            end else begin
               ram_wr_en        = 1'b1;
               valid_in[pos_ff] = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_INS_WR: begin
            ram_wr_en        = 1'b1;
            valid_in[pos_ff] = 1'b1;
            state_in         = S_IDLE;
         end
         S_RO_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_RO_LOAD;
         end
         S_RO_LOAD: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = ent;
               rsp_user_in   = ent_valid;
               rsp_tlast_in  = (rp_ff == k_last);
               if (rp_ff == k_last) begin
                  state_in = S_IDLE;
               end else begin
                  rp_in    = rp_ff + IDX_W'(1);
                  state_in = S_RO_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         k_ff          <= K_RESET;
         rsp_tvalid_ff <= 1'b0;
         first_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         k_ff          <= k_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         first_ff      <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      rp_ff        <= rp_in;
      id_ff        <= id_in;
      last_ff      <= last_in;
      rsp_tlast_ff <= rsp_tlast_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_data_ff  <= rsp_data_in;
      if (ram_rd_en) begin
         rd_addr_ff <= ram_rd_addr;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-ENTRY_W){1'b0}}, rsp_data_ff.sq_dist, rsp_data_ff.id};

   a_ro_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RO_RD || state_ff == S_RO_LOAD) |-> rp_ff <= k_last)
      else $error("read-out index beyond active list");

   a_ins_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_CMP || state_ff == S_INS_WR) |-> pos_ff <= k_last)
      else $error("insertion slot beyond active list");

   a_cmp_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_CMP) |-> $past(state_ff) == S_INS_RD)
      else $error("compare without a preceding list read");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == OP_CLEAR) |=> valid_ff == '0)
      else $error("clear left entries valid");

endmodule

[rtl/knn_ram.sv]
// Generic single-port-write, registered-read RAM.
module knn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/knn_sqacc.sv]
// Shared square-and-accumulate unit with saturating squared-distance sum.
module knn_sqacc (
   input  logic                                clock,
   input  logic                                reset,
   input  knn_pkg::sqacc_ctrl_type             ctrl,
   input  logic signed [knn_pkg::COORD_W-1:0]  point_coord,
   input  logic signed [knn_pkg::COORD_W-1:0]  query_coord,
   output logic [knn_pkg::DIST_W-1:0]          sum_dist
);
   import knn_pkg::*;

   logic signed [COORD_W-1:0] pc_ff;
   logic signed [COORD_W-1:0] qc_ff;
   logic signed [COORD_W:0]   diff;
   logic [COORD_W:0]          mag;
   logic [2*COORD_W+1:0]      prod;
   logic [SQ_W-1:0]           sq_ff;
   logic [DIST_W:0]           sum_wide;
   logic [DIST_W-1:0]         sum_sat;
   logic [DIST_W-1:0]         sum_ff;
   logic [DIST_W-1:0]         sum_in;
   logic [DIST_W-1:0]         dist_ff;

   always_comb begin
      diff     = {pc_ff[COORD_W-1], pc_ff} - {qc_ff[COORD_W-1], qc_ff};
      mag      = diff[COORD_W] ? (~diff + 1'b1) : diff;
      prod     = {{(COORD_W+1){1'b0}}, mag} * {{(COORD_W+1){1'b0}}, mag};
      sum_wide = {1'b0, sum_ff} + {{(DIST_W+1-SQ_W){1'b0}}, sq_ff};
      sum_sat  = sum_wide[DIST_W] ? DIST_INF : sum_wide[DIST_W-1:0];
      sum_in   = sum_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.accum) begin
         sum_in = ctrl.last ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         pc_ff <= point_coord;
         qc_ff <= query_coord;
      end
      if (ctrl.square) begin
         sq_ff <= prod[SQ_W-1:0];
      end
      if (ctrl.accum && ctrl.last) begin
         dist_ff <= sum_sat;
      end
   end

   assign sum_dist = dist_ff;

endmodule

[bench/tb_knn_topk_selector_unit.sv]
// Self-checking bench for knn_topk_selector_unit: directed table, then random point streams.
module tb_knn_topk_selector_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import knn_pkg::*;

   localparam int LIST_DEPTH     = DEF_LIST_DEPTH;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BEATS    = 48;
   localparam int DIR_ROWS       = 12;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   typedef enum logic [1:0] {CHK_MODEL, CHK_EMPTY, CHK_TOP} chk_mode_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COORD_W-1:0] pc;
      logic [COORD_W-1:0] qc;
      logic [ID_W-1:0]    id;
      logic               last;
   } beat_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] sq_dist;
      logic              valid;
      logic              last;
   } entry_rec_type;

   typedef struct packed {
      beat_type          beat;
      logic [4:0]        reps;
      chk_mode_type      chk;
      logic [ID_W-1:0]   top_id;
      logic [DIST_W-1:0] top_dist;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  req_tlast;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_wr_en;
   logic [K_W-1:0]        csr_wr_data;

   knn_topk_selector_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the neighbour list; entry 0 is the worst
   logic [DIST_W-1:0] near_dist  [LIST_DEPTH];
   logic [ID_W-1:0]   near_id    [LIST_DEPTH];
   logic              near_valid [LIST_DEPTH];
   logic [DIST_W-1:0] run_sum;
   logic [K_W-1:0]    k_reg;
   entry_rec_type     readout    [LIST_DEPTH];
   entry_rec_type     entry_q    [$];

   int   errors;
   int   stall_cycles;
   int   req_idle_pct;
   int   rsp_idle_pct;
   logic running;

   logic [K_W-1:0] k_plan [6] = '{4'd1, 4'd15, 4'd0, 4'd5, 4'd8, 4'd3};

   // k = 8 after reset
   dir_row_type dir_tab [DIR_ROWS] = '{
      '{'{OP_READ,  16'h0000, 16'h0000, 16'h0000, 1'b0}, 5'd1,  CHK_EMPTY, 16'h0, 36'h0},
      '{'{OP_COORD, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1}, 5'd1,  CHK_MODEL, 16'h0, 36'h0},
      '{'{OP_NONE,  16'h5A5A, 16'hA5A5, 16'h1234, 1'b1}, 5'd1,  CHK_MODEL, 16'h0, 36'h0},
      // 17 max squares saturate the sum; never inserted
      '{'{OP_COORD, 16'h7FFF, 16'h8000, 16'h0001, 1'b1}, 5'd17, CHK_MODEL, 16'h0, 36'h0},
      '{'{OP_READ,  16'h0000, 16'h0000, 16'h0000, 1'b0}, 5'd1,  CHK_TOP,
        16'hFFFF, 36'h0_FFFE_0001},
      '{'{OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 5'd1,  CHK_MODEL, 16'h0, 36'h0},
      // equal distances, newer is nearer
      '{'{OP_COORD, 16'h0005, 16'h0005, 16'h00AA, 1'b1}, 5'd1,  CHK_MODEL, 16'h0, 36'h0},
      '{'{OP_COORD, 16'hFFF9, 16'hFFF9, 16'h0055, 1'b1}, 5'd1,  CHK_MODEL, 16'h0, 36'h0},
      // clear in mid-point drops the partial sum
      '{'{OP_COORD, 16'h0064, 16'h0000, 16'h0007, 1'b0}, 5'd1,  CHK_MODEL, 16'h0, 36'h0},
      '{'{OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 5'd1,  CHK_MODEL, 16'h0, 36'h0},
      '{'{OP_COORD, 16'h0000, 16'h0001, 16'h0008, 1'b1}, 5'd1,  CHK_MODEL, 16'h0, 36'h0},
      '{'{OP_READ,  16'h0000, 16'h0000, 16'h0000, 1'b0}, 5'd1,  CHK_MODEL, 16'h0, 36'h0}
   };

   always #1 clock = ~clock;

   function automatic int active_count();
      if (k_reg == '0)
         return 1;
      if (k_reg > K_W'(LIST_DEPTH))
         return LIST_DEPTH;
      return int'(k_reg);
   endfunction

   function automatic void clear_near();
      for (int i = 0; i < LIST_DEPTH; i++) begin
         near_dist[i]  = DIST_INF;
         near_id[i]    = '0;
         near_valid[i] = 1'b0;
      end
      run_sum = '0;
   endfunction

   task automatic model_beat(input beat_type b, output int n);
      logic [16:0]       diff;
      logic [16:0]       mag;
      logic [33:0]       sq;
      logic [36:0]       total;
      logic [DIST_W-1:0] d;
      int                kc;
      int                pos;
      kc = active_count();
      n  = 0;
      case (b.op)
         OP_COORD: begin
            diff  = {b.pc[15], b.pc} - {b.qc[15], b.qc};
            mag   = diff[16] ? -diff : diff;
            sq    = {17'd0, mag} * {17'd0, mag};
            total = {1'b0, run_sum} + {3'd0, sq};
            if (total > {1'b0, DIST_INF})
               total = {1'b0, DIST_INF};
            d = total[DIST_W-1:0];
            if (b.last) begin
               if (d < near_dist[0]) begin
                  pos = 0;
                  while (pos < kc - 1 && near_dist[pos+1] >= d) begin
                     near_dist[pos]  = near_dist[pos+1];
                     near_id[pos]    = near_id[pos+1];
                     near_valid[pos] = near_valid[pos+1];
                     pos++;
                  end
                  near_dist[pos]  = d;
                  near_id[pos]    = b.id;
                  near_valid[pos] = 1'b1;
               end
               run_sum = '0;
            end else begin
               run_sum = d;
            end
         end
         OP_CLEAR: clear_near();
         OP_READ: begin
            for (int i = 0; i < kc; i++)
               readout[i] = '{near_id[i], near_dist[i], near_valid[i], i == kc - 1};
            n = kc;
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: %s got %0h, want %0h", $realtime, what, got, want);
      errors++;
   endtask

   task automatic send_beat(input beat_type b, input chk_mode_type chk,
                            input entry_rec_type top);
      int            n;
      int            i;
      entry_rec_type rec;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= b.op;
      req_tdata  <= {b.id, b.qc, b.pc};
      req_tlast  <= b.last;
      do @(posedge clock); while (!req_tready);
      model_beat(b, n);
      for (i = 0; i < n; i++) begin
         rec = readout[i];
         if (chk != CHK_MODEL)
            rec = '{'0, DIST_INF, 1'b0, i == n - 1};
         if (chk == CHK_TOP && i == n - 1) begin
            rec.id      = top.id;
            rec.sq_dist = top.sq_dist;
            rec.valid   = 1'b1;
         end
         entry_q.push_back(rec);
      end
   endtask

   task automatic wait_drained(input int extra);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (entry_q.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_k(input logic [K_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      k_reg = value;
   endtask

   task automatic random_phase(input int target);
      int       issued;
      int       sel;
      int       dims;
      int       d;
      logic     tiny;
      logic     paused;
      beat_type b;
      issued = 0;
      paused = 1'b0;
      while (issued < target) begin
         if (!paused && issued >= target / 2) begin
            wait_drained(0);
            paused = 1'b1;
         end
         sel    = $urandom_range(99);
         b.pc   = 16'($urandom);
         b.qc   = 16'($urandom);
         b.id   = 16'($urandom);
         b.last = 1'($urandom_range(1));
         if (sel < 10) begin
            b.op = OP_READ;
            send_beat(b, CHK_MODEL, '0);
            issued++;
         end else if (sel < 13) begin
            b.op = OP_CLEAR;
            send_beat(b, CHK_MODEL, '0);
            issued++;
         end else if (sel < 15) begin
            b.op = OP_NONE;
            send_beat(b, CHK_MODEL, '0);
         end else if (sel < 19) begin
            // stray coordinate beat, random last
            b.op = OP_COORD;
            send_beat(b, CHK_MODEL, '0);
            issued++;
         end else begin
            b.op = OP_COORD;
            dims = ($urandom_range(99) < 6) ? $urandom_range(17, 20) : $urandom_range(1, 4);
            tiny = 1'($urandom_range(1));
            for (d = 0; d < dims; d++) begin
               if (dims > 16) begin
                  b.pc = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                  b.qc = ~b.pc;
               end else if (tiny) begin
                  b.pc = 16'($urandom_range(4)) - 16'd2;
                  b.qc = 16'($urandom_range(4)) - 16'd2;
               end else begin
                  b.pc = 16'($urandom);
                  b.qc = 16'($urandom);
               end
               b.last = (d == dims - 1);
               send_beat(b, CHK_MODEL, '0);
               issued++;
            end
         end
      end
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);

   always @(posedge clock) begin
      entry_rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (entry_q.size() == 0) begin
            report_mismatch("unexpected result beat, entry_id", 64'(rsp_tdata[15:0]), '0);
         end else begin
            want = entry_q.pop_front();
            if (rsp_tdata[15:0] !== want.id)
               report_mismatch("entry_id", 64'(rsp_tdata[15:0]), 64'(want.id));
            if (rsp_tdata[51:16] !== want.sq_dist)
               report_mismatch("entry_dist", 64'(rsp_tdata[51:16]), 64'(want.sq_dist));
            if (rsp_tuser !== want.valid)
               report_mismatch("entry_valid", 64'(rsp_tuser), 64'(want.valid));
            if (rsp_tlast !== want.last)
               report_mismatch("last_entry", 64'(rsp_tlast), 64'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (running) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("knn_topk_selector_unit: mismatch");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      beat_type      b;
      entry_rec_type top;
      int            r;
      int            p;
      int            n;
      clock        = 1'b0;
      reset        = 1'b1;
      req_tdata    = '0;
      req_tuser    = '0;
      req_tlast    = 1'b0;
      req_tvalid   = 1'b0;
      rsp_tready   = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      errors       = 0;
      stall_cycles = 0;
      running      = 1'b0;
      req_idle_pct = 21;
      rsp_idle_pct = 80;
      k_reg        = K_RESET;
      clear_near();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset   <= 1'b0;
      running = 1'b1;

      for (r = 0; r < DIR_ROWS; r++) begin
         top = '{dir_tab[r].top_id, dir_tab[r].top_dist, 1'b1, 1'b1};
         for (n = 0; n < int'(dir_tab[r].reps); n++) begin
            b      = dir_tab[r].beat;
            b.last = dir_tab[r].beat.last && (n == int'(dir_tab[r].reps) - 1);
            send_beat(b, dir_tab[r].chk, top);
         end
      end

      for (p = 0; p < 6; p++) begin
         if (p == 2) begin
            req_idle_pct = 80;
            rsp_idle_pct = 21;
         end
         if (p == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         wait_drained(DRAIN_CYCLES);
         write_k(k_plan[p]);
         random_phase(PHASE_BEATS);
      end

      wait_drained(DRAIN_CYCLES);
      if (errors == 0)
         $display("knn_topk_selector_unit: match");
      else
         $display("knn_topk_selector_unit: mismatch");
      $finish;
   end

endmodule

[filelist.f]
rtl/knn_pkg.sv
rtl/knn_ram.sv
rtl/knn_sqacc.sv
rtl/knn_topk_selector_unit.sv
bench/tb_knn_topk_selector_unit.sv
